>>> hdl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes for the round-robin task selector.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

    localparam int IN_W  = 24;
    localparam int OUT_W = 40;

    localparam logic [2:0] ACT_CREATE     = 3'd0;
    localparam logic [2:0] ACT_SET_STATUS = 3'd1;
    localparam logic [2:0] ACT_SET_TARGET = 3'd2;
    localparam logic [2:0] ACT_YIELD      = 3'd3;
    localparam logic [2:0] ACT_SET_READY  = 3'd4;

    localparam logic [2:0] STAT_READY    = 3'd0;
    localparam logic [2:0] STAT_ACTIVE   = 3'd1;
    localparam logic [2:0] STAT_INACTIVE = 3'd3;
    localparam logic [2:0] STAT_DEAD     = 3'd4;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_FULL    = 2'd2;

    localparam logic [15:0] FIRST_IDENT = 16'd1000;

    typedef struct packed {
        logic        ready;
        logic [15:0] parent;
        logic [2:0]  status;
        logic [15:0] ident;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic start;
        logic by_ident;
    } scan_cmd_t;

    typedef struct packed {
        logic done;
        logic found;
    } scan_stat_t;

endpackage

`default_nettype wire

>>> hdl/rrts_ram.sv
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/rrts_scan.sv
// ----------------------------------------------------------------------------
// rrts_scan
// Slot table search: one read per cycle, wrapping at the slot count, stops at
// the first entry whose id matches the key or whose status is eligible.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_scan #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire rrts_pkg::scan_cmd_t                cmd,
    input  wire logic [15:0]                        key,
    input  wire logic [$clog2(MAX_TASKS)-1:0]       first_idx,
    input  wire logic [$clog2(MAX_TASKS+1)-1:0]     length,
    output logic                                    rd_en,
    output logic      [$clog2(MAX_TASKS)-1:0]       rd_addr,
    input  wire rrts_pkg::entry_t                   rd_data,
    output rrts_pkg::scan_stat_t                    stat,
    output logic      [$clog2(MAX_TASKS)-1:0]       hit_idx,
    output rrts_pkg::entry_t                        hit_entry
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic                 active_reg, active_next;
    logic                 by_ident_reg, by_ident_next;
    logic [15:0]          key_reg, key_next;
    logic [CW-1:0]        len_reg, len_next;
    logic [IW-1:0]        issue_idx_reg, issue_idx_next;
    logic [CW-1:0]        left_reg, left_next;
    logic                 pend_reg, pend_next;
    logic [IW-1:0]        pend_idx_reg, pend_idx_next;
    rrts_pkg::scan_stat_t stat_reg, stat_next;
    logic [IW-1:0]        hit_idx_reg, hit_idx_next;
    rrts_pkg::entry_t     hit_entry_reg, hit_entry_next;

    logic          match;
    logic [CW-1:0] idx_inc;

    assign match = pend_reg && (by_ident_reg ? (rd_data.ident == key_reg)
                                             : (rd_data.status <= rrts_pkg::STAT_INACTIVE));
    assign idx_inc = {{(CW-IW){1'b0}}, issue_idx_reg} + CW'(1);

    always_comb
    begin
        active_next    = active_reg;
        by_ident_next  = by_ident_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        issue_idx_next = issue_idx_reg;
        left_next      = left_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        stat_next      = '0;
        hit_idx_next   = hit_idx_reg;
        hit_entry_next = hit_entry_reg;
        rd_en          = 1'b0;
        rd_addr        = issue_idx_reg;

        if (cmd.start)
        begin
            active_next    = 1'b1;
            by_ident_next  = cmd.by_ident;
            key_next       = key;
            len_next       = length;
            issue_idx_next = first_idx;
            left_next      = length;
            pend_next      = 1'b0;
        end
        else if (active_reg)
        begin
            if (match)
            begin
                stat_next.done  = 1'b1;
                stat_next.found = 1'b1;
                hit_idx_next    = pend_idx_reg;
                hit_entry_next  = rd_data;
                active_next     = 1'b0;
                pend_next       = 1'b0;
            end
            else if (left_reg == '0 && !pend_reg)
            begin
                stat_next.done = 1'b1;
                active_next    = 1'b0;
            end
            else if (left_reg != '0)
            begin
                rd_en          = 1'b1;
                pend_next      = 1'b1;
                pend_idx_next  = issue_idx_reg;
                left_next      = left_reg - CW'(1);
                issue_idx_next = (idx_inc == len_reg) ? '0 : idx_inc[IW-1:0];
            end
            else
            begin
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
            stat_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            pend_reg   <= pend_next;
            stat_reg   <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        by_ident_reg  <= by_ident_next;
        key_reg       <= key_next;
        len_reg       <= len_next;
        issue_idx_reg <= issue_idx_next;
        left_reg      <= left_next;
        pend_idx_reg  <= pend_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_entry_reg <= hit_entry_next;
    end

    assign stat      = stat_reg;
    assign hit_idx   = hit_idx_reg;
    assign hit_entry = hit_entry_reg;

endmodule

`default_nettype wire

>>> hdl/round_robin_task_selector.sv
// ----------------------------------------------------------------------------
// round_robin_task_selector
// Task slot table in RAM with id lookup, round-robin and directed yield.
// ----------------------------------------------------------------------------
// Create, set-target, kernel create, full table and unknown action: go
// straight to S_DONE, which loads the output register once it is free.
// Set-status / set-ready: serial id search, one RAM read per cycle. Yield:
// search, then read-modify-write of the old slot and write of the new one.
// One item in flight; the next is taken while a result waits in m_tdata.
// Reset: async, active low; the S_INIT state after reset seeds slot 0 in the RAM.
`default_nettype none

module round_robin_task_selector #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // action[2:0], task_id[18:3], kernel_type[19], new_status[22:20],
    // ready_flag[23]
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // result_id[15:0], previous_id[31:16], error_code[33:32], zero pad
    output logic      [39:0] m_tdata
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_RDCUR = 7'b0001000,
        S_WRCUR = 7'b0010000,
        S_WRTGT = 7'b0100000,
        S_DONE  = 7'b1000000
    } fsm_t;

    fsm_t             state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [15:0]      next_ident_reg, next_ident_next;
    logic [IW-1:0]    cur_slot_reg, cur_slot_next;
    logic [15:0]      cur_ident_reg, cur_ident_next;
    logic [15:0]      yield_tgt_reg, yield_tgt_next;
    logic [2:0]       action_reg, action_next;
    logic [2:0]       new_status_reg, new_status_next;
    logic             ready_flag_reg, ready_flag_next;
    logic             directed_reg, directed_next;
    logic [15:0]      res_id_reg, res_id_next;
    logic [15:0]      prev_id_reg, prev_id_next;
    logic [1:0]       err_reg, err_next;
    logic [IW-1:0]    tgt_idx_reg, tgt_idx_next;
    rrts_pkg::entry_t tgt_entry_reg, tgt_entry_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [39:0]      m_tdata_reg, m_tdata_next;

    logic [2:0]  in_action;
    logic [15:0] in_task_id;
    logic        in_kernel;
    logic        accept;

    rrts_pkg::scan_cmd_t  scan_cmd;
    rrts_pkg::scan_stat_t scan_stat;
    logic [15:0]          scan_key;
    logic [IW-1:0]        scan_first;
    logic                 scan_rd_en;
    logic [IW-1:0]        scan_rd_addr;
    logic [IW-1:0]        hit_idx;
    rrts_pkg::entry_t     hit_entry;

    logic                         ram_wr_en;
    logic [IW-1:0]                ram_wr_addr;
    rrts_pkg::entry_t             ram_wr_entry;
    logic                         ram_rd_en;
    logic [IW-1:0]                ram_rd_addr;
    logic [rrts_pkg::ENTRY_W-1:0] ram_rd_data;
    rrts_pkg::entry_t             rd_entry;

    logic [CW-1:0] cur_inc;

    assign in_action  = s_tdata[2:0];
    assign in_task_id = s_tdata[18:3];
    assign in_kernel  = s_tdata[19];
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign rd_entry   = rrts_pkg::entry_t'(ram_rd_data);
    assign cur_inc    = {{(CW-IW){1'b0}}, cur_slot_reg} + CW'(1);

    assign ram_rd_en   = scan_rd_en || (state_reg == S_RDCUR);
    assign ram_rd_addr = (state_reg == S_RDCUR) ? cur_slot_reg : scan_rd_addr;

    rrts_ram #(
        .WIDTH(rrts_pkg::ENTRY_W),
        .DEPTH(MAX_TASKS)
    ) u_table (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_entry),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    rrts_scan #(
        .MAX_TASKS(MAX_TASKS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (scan_cmd),
        .key      (scan_key),
        .first_idx(scan_first),
        .length   (count_reg),
        .rd_en    (scan_rd_en),
        .rd_addr  (scan_rd_addr),
        .rd_data  (rd_entry),
        .stat     (scan_stat),
        .hit_idx  (hit_idx),
        .hit_entry(hit_entry)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        next_ident_next = next_ident_reg;
        cur_slot_next   = cur_slot_reg;
        cur_ident_next  = cur_ident_reg;
        yield_tgt_next  = yield_tgt_reg;
        action_next     = action_reg;
        new_status_next = new_status_reg;
        ready_flag_next = ready_flag_reg;
        directed_next   = directed_reg;
        res_id_next     = res_id_reg;
        prev_id_next    = prev_id_reg;
        err_next        = err_reg;
        tgt_idx_next    = tgt_idx_reg;
        tgt_entry_next  = tgt_entry_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        scan_cmd     = '0;
        scan_key     = in_task_id;
        scan_first   = '0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = '0;
        ram_wr_entry = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                ram_wr_en           = 1'b1;
                ram_wr_entry.status = rrts_pkg::STAT_ACTIVE;
                state_next          = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    action_next     = in_action;
                    new_status_next = s_tdata[22:20];
                    ready_flag_next = s_tdata[23];
                    res_id_next     = '0;
                    prev_id_next    = '0;
                    err_next        = rrts_pkg::ERR_OK;
                    state_next      = S_DONE;
                    case (in_action)
                        rrts_pkg::ACT_CREATE:
                        begin
                            if (!in_kernel)
                            begin
                                if (count_reg == CW'(MAX_TASKS))
                                begin
                                    err_next = rrts_pkg::ERR_FULL;
                                end
                                else
                                begin
                                    ram_wr_en           = 1'b1;
                                    ram_wr_addr         = count_reg[IW-1:0];
                                    ram_wr_entry.ident  = next_ident_reg;
                                    ram_wr_entry.status = rrts_pkg::STAT_READY;
                                    ram_wr_entry.parent = cur_ident_reg;
                                    ram_wr_entry.ready  = 1'b0;
                                    res_id_next         = next_ident_reg;
                                    next_ident_next     = next_ident_reg + 16'd1;
                                    count_next          = count_reg + CW'(1);
                                end
                            end
                        end
                        rrts_pkg::ACT_SET_STATUS, rrts_pkg::ACT_SET_READY:
                        begin
                            scan_cmd.start    = 1'b1;
                            scan_cmd.by_ident = 1'b1;
                            state_next        = S_SCAN;
                        end
                        rrts_pkg::ACT_SET_TARGET:
                        begin
                            yield_tgt_next = in_task_id;
                        end
                        rrts_pkg::ACT_YIELD:
                        begin
                            res_id_next    = cur_ident_reg;
                            prev_id_next   = cur_ident_reg;
                            scan_cmd.start = 1'b1;
                            state_next     = S_SCAN;
                            if (yield_tgt_reg == '0)
                            begin
                                directed_next = 1'b0;
                                scan_first    = (cur_inc == count_reg) ? '0 : cur_inc[IW-1:0];
                            end
                            else
                            begin
                                directed_next     = 1'b1;
                                scan_cmd.by_ident = 1'b1;
                                scan_key          = yield_tgt_reg;
                                yield_tgt_next    = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_stat.done)
                begin
                    state_next   = S_DONE;
                    ram_wr_addr  = hit_idx;
                    ram_wr_entry = hit_entry;
                    if (!scan_stat.found)
                    begin
                        if (action_reg != rrts_pkg::ACT_YIELD || directed_reg)
                        begin
                            err_next = rrts_pkg::ERR_UNKNOWN;
                        end
                    end
                    else if (action_reg == rrts_pkg::ACT_SET_STATUS)
                    begin
                        ram_wr_en           = 1'b1;
                        ram_wr_entry.status = new_status_reg;
                    end
                    else if (action_reg == rrts_pkg::ACT_SET_READY)
                    begin
                        ram_wr_en          = 1'b1;
                        ram_wr_entry.ready = ready_flag_reg;
                    end
                    else
                    begin
                        tgt_idx_next   = hit_idx;
                        tgt_entry_next = hit_entry;
                        state_next     = S_RDCUR;
                    end
                end
            end
            S_RDCUR:
            begin
                state_next = S_WRCUR;
            end
            S_WRCUR:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = cur_slot_reg;
                ram_wr_entry = rd_entry;
                if (rd_entry.status != rrts_pkg::STAT_DEAD)
                begin
                    ram_wr_entry.status = rrts_pkg::STAT_INACTIVE;
                end
                state_next = S_WRTGT;
            end
            S_WRTGT:
            begin
                ram_wr_en           = 1'b1;
                ram_wr_addr         = tgt_idx_reg;
                ram_wr_entry        = tgt_entry_reg;
                ram_wr_entry.status = rrts_pkg::STAT_ACTIVE;
                cur_slot_next       = tgt_idx_reg;
                cur_ident_next      = tgt_entry_reg.ident;
                res_id_next         = tgt_entry_reg.ident;
                state_next          = S_DONE;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, err_reg, prev_id_reg, res_id_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            count_reg      <= CW'(1);
            next_ident_reg <= rrts_pkg::FIRST_IDENT;
            cur_slot_reg   <= '0;
            cur_ident_reg  <= '0;
            yield_tgt_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            next_ident_reg <= next_ident_next;
            cur_slot_reg   <= cur_slot_next;
            cur_ident_reg  <= cur_ident_next;
            yield_tgt_reg  <= yield_tgt_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        new_status_reg <= new_status_next;
        ready_flag_reg <= ready_flag_next;
        directed_reg   <= directed_next;
        res_id_reg     <= res_id_next;
        prev_id_reg    <= prev_id_next;
        err_reg        <= err_next;
        tgt_idx_reg    <= tgt_idx_next;
        tgt_entry_reg  <= tgt_entry_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> hdl/rrts_checker.sv
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks for the round-robin task selector, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while another is in flight");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without an item in flight");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[33:32] != 2'd3)
        else $error("undefined error code");

    a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33:32] == 2'd2 |-> m_tdata[31:0] == 32'd0)
        else $error("full table result carries an id");

endmodule

bind round_robin_task_selector rrts_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the round-robin task selector. A short directed
// table walks through reset state, kernel and full-table creates, unknown ids,
// directed and round-robin yields and unused action codes. Random scheduler
// traffic follows. Every command goes through an in-bench model of the slot
// table, and each response is compared in order with the expected one.
// ----------------------------------------------------------------------------

module testbench;

    localparam int          TASK_SLOTS     = 16;
    localparam int          RANDOM_ITEMS   = 1450;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          DRAIN_CYCLES   = 40;
    localparam logic [15:0] NO_TARGET      = 16'd0;
    localparam logic [2:0]  ACT_UNUSED_LO  = 3'd5;
    localparam logic [2:0]  ACT_UNUSED_HI  = 3'd7;
    localparam logic [2:0]  STAT_WAIT      = 3'd2;
    localparam logic [2:0]  STAT_TOP       = 3'd7;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] task_id;
        logic        kernel_type;
        logic [2:0]  new_status;
        logic        ready_flag;
    } command_t;

    typedef struct packed {
        logic [15:0] result_id;
        logic [15:0] previous_id;
        logic [1:0]  error_code;
    } outcome_t;

    typedef struct {
        command_t cmd;
        bit       known;
        outcome_t want;
        int       copies;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    // scheduler model state
    logic [15:0] task_ident  [TASK_SLOTS];
    logic [2:0]  task_state  [TASK_SLOTS];
    logic [15:0] task_parent [TASK_SLOTS];
    logic        task_ready  [TASK_SLOTS];
    int          task_count;
    logic [15:0] next_id;
    int          cur_slot;
    logic [15:0] pending_target;

    outcome_t    pending_outcomes[$];
    row_t        directed[$];
    int          fail_count  = 0;
    int          idle_cycles = 0;
    int          stall_left  = 0;
    bit          no_idle;

    round_robin_task_selector #(
        .MAX_TASKS (TASK_SLOTS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // first slot in creation order holding id, task_count if none
    function automatic int find_task(logic [15:0] id);
        int i;
        int hit;
        hit = task_count;
        for (i = task_count - 1; i >= 0; i--)
            if (task_ident[i] == id)
                hit = i;
        return hit;
    endfunction

    function automatic outcome_t run_command(command_t c);
        outcome_t o;
        int       s;
        int       k;
        int       cur;
        int       tgt;
        o.result_id   = 16'd0;
        o.previous_id = 16'd0;
        o.error_code  = rrts_pkg::ERR_OK;
        if (cur_slot >= task_count)
            cur_slot = 0;
        cur = cur_slot;
        case (c.action)
            rrts_pkg::ACT_CREATE:
            begin
                if (!c.kernel_type)
                begin
                    if (task_count >= TASK_SLOTS)
                    begin
                        o.error_code = rrts_pkg::ERR_FULL;
                    end
                    else
                    begin
                        s = task_count;
                        task_ident[s]  = next_id;
                        task_state[s]  = rrts_pkg::STAT_READY;
                        task_parent[s] = task_ident[cur];
                        task_ready[s]  = 1'b0;
                        task_count     = s + 1;
                        o.result_id    = next_id;
                        next_id        = next_id + 16'd1;
                    end
                end
            end
            rrts_pkg::ACT_SET_STATUS:
            begin
                s = find_task(c.task_id);
                if (s >= task_count)
                    o.error_code = rrts_pkg::ERR_UNKNOWN;
                else
                    task_state[s] = c.new_status;
            end
            rrts_pkg::ACT_SET_TARGET:
                pending_target = c.task_id;
            rrts_pkg::ACT_YIELD:
            begin
                o.previous_id = task_ident[cur];
                o.result_id   = o.previous_id;
                tgt = task_count;
                if (pending_target == NO_TARGET)
                begin
                    for (k = 1; k <= task_count; k++)
                    begin
                        s = (cur + k) % task_count;
                        if (tgt == task_count && task_state[s] <= rrts_pkg::STAT_INACTIVE)
                            tgt = s;
                    end
                end
                else
                begin
                    tgt = find_task(pending_target);
                    pending_target = NO_TARGET;
                    if (tgt >= task_count)
                        o.error_code = rrts_pkg::ERR_UNKNOWN;
                end
                if (tgt < task_count)
                begin
                    if (task_state[cur] != rrts_pkg::STAT_DEAD)
                        task_state[cur] = rrts_pkg::STAT_INACTIVE;
                    task_state[tgt] = rrts_pkg::STAT_ACTIVE;
                    cur_slot    = tgt;
                    o.result_id = task_ident[tgt];
                end
            end
            rrts_pkg::ACT_SET_READY:
            begin
                s = find_task(c.task_id);
                if (s >= task_count)
                    o.error_code = rrts_pkg::ERR_UNKNOWN;
                else
                    task_ready[s] = c.ready_flag;
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic logic [15:0] known_id();
        return task_ident[$urandom_range(0, task_count - 1)];
    endfunction

    function automatic command_t make_random_command();
        command_t c;
        int       r;
        c.task_id     = 16'($urandom_range(0, 16'hFFFF));
        c.kernel_type = 1'($urandom_range(0, 1));
        c.new_status  = 3'($urandom_range(0, STAT_TOP));
        c.ready_flag  = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            c.action = rrts_pkg::ACT_YIELD;
        end
        else if (r < 67 && r >= 55)
        begin
            c.action = rrts_pkg::ACT_SET_TARGET;
            r = $urandom_range(0, 99);
            if (r < 35)
                c.task_id = NO_TARGET;
            else if (r < 85)
                c.task_id = known_id();
        end
        else if (r < 79)
        begin
            c.action = (r < 55) ? rrts_pkg::ACT_SET_STATUS : rrts_pkg::ACT_SET_READY;
            if ($urandom_range(0, 99) < 85)
                c.task_id = known_id();
            if ($urandom_range(0, 99) < 75)
                c.new_status = 3'($urandom_range(rrts_pkg::STAT_READY,
                                                 rrts_pkg::STAT_INACTIVE));
        end
        else if (r < 92)
        begin
            c.action      = rrts_pkg::ACT_CREATE;
            c.kernel_type = ($urandom_range(0, 99) < 25);
        end
        else
        begin
            c.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        end
        return c;
    endfunction

    task automatic add_row(input logic [2:0] action, input int id, input int kern,
                           input logic [2:0] stat, input int rdy, input int known,
                           input int res, input int prev, input logic [1:0] err,
                           input int copies);
        row_t row;
        row.cmd.action       = action;
        row.cmd.task_id      = 16'(id);
        row.cmd.kernel_type  = 1'(kern);
        row.cmd.new_status   = stat;
        row.cmd.ready_flag   = 1'(rdy);
        row.known            = (known != 0);
        row.want.result_id   = 16'(res);
        row.want.previous_id = 16'(prev);
        row.want.error_code  = err;
        row.copies           = copies;
        directed.push_back(row);
    endtask

    // drain: hold off until every outstanding response has come back
    task automatic issue(input command_t c, input bit known, input outcome_t want,
                         input bit drain);
        int       gap;
        outcome_t got;
        gap = pick_gap();
        if (drain && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            while (drain && pending_outcomes.size() != 0)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.ready_flag, c.new_status, c.kernel_type, c.task_id, c.action};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        got = run_command(c);
        pending_outcomes.push_back(known ? want : got);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap();
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        outcome_t exp_o;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected item, got result_id %h previous_id %h error_code %h",
                         $time, m_tdata[15:0], m_tdata[31:16], m_tdata[33:32]);
            end
            else
            begin
                exp_o = pending_outcomes.pop_front();
                if (m_tdata[15:0] !== exp_o.result_id)
                begin
                    fail_count++;
                    $display("%0t: result_id exp %h got %h",
                             $time, exp_o.result_id, m_tdata[15:0]);
                end
                if (m_tdata[31:16] !== exp_o.previous_id)
                begin
                    fail_count++;
                    $display("%0t: previous_id exp %h got %h",
                             $time, exp_o.previous_id, m_tdata[31:16]);
                end
                if (m_tdata[33:32] !== exp_o.error_code)
                begin
                    fail_count++;
                    $display("%0t: error_code exp %h got %h",
                             $time, exp_o.error_code, m_tdata[33:32]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d responses outstanding",
                         $time, pending_outcomes.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        outcome_t blank;
        int       i;
        int       n;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        no_idle        = 1'b0;
        blank          = '0;
        task_ident[0]  = 16'd0;
        task_state[0]  = rrts_pkg::STAT_ACTIVE;
        task_ready[0]  = 1'b0;
        task_count     = 1;
        next_id        = rrts_pkg::FIRST_IDENT;
        cur_slot       = 0;
        pending_target = NO_TARGET;
        for (i = 1; i < TASK_SLOTS; i++)
            task_ready[i] = 1'b0;

        // action, id, kern, status /
        //     rdy, known, res, prev, err, copies
        add_row(rrts_pkg::ACT_YIELD,      0,     0, rrts_pkg::STAT_READY,
                0, 1, 0,    0,    rrts_pkg::ERR_OK,      1);
        add_row(rrts_pkg::ACT_SET_STATUS, 0,     0, rrts_pkg::STAT_DEAD,
                0, 1, 0,    0,    rrts_pkg::ERR_OK,      1);
        // nothing eligible: no switch
        add_row(rrts_pkg::ACT_YIELD,      0,     0, rrts_pkg::STAT_READY,
                0, 1, 0,    0,    rrts_pkg::ERR_OK,      1);
        add_row(rrts_pkg::ACT_SET_STATUS, 0,     0, rrts_pkg::STAT_ACTIVE,
                0, 1, 0,    0,    rrts_pkg::ERR_OK,      1);
        add_row(rrts_pkg::ACT_CREATE,     0,     1, rrts_pkg::STAT_READY,
                0, 1, 0,    0,    rrts_pkg::ERR_OK,      1);
        add_row(rrts_pkg::ACT_CREATE,     0,     0, rrts_pkg::STAT_READY,
                0, 1, 1000, 0,    rrts_pkg::ERR_OK,      1);
        add_row(rrts_pkg::ACT_CREATE,     0,     0, rrts_pkg::STAT_READY,
                0, 1, 1001, 0,    rrts_pkg::ERR_OK,      1);
        add_row(rrts_pkg::ACT_SET_READY,  1000,  0, rrts_pkg::STAT_READY,
                1, 1, 0,    0,    rrts_pkg::ERR_OK,      1);
        add_row(rrts_pkg::ACT_SET_STATUS, 65535, 0, STAT_WAIT,
                0, 1, 0,    0,    rrts_pkg::ERR_UNKNOWN, 1);
        add_row(rrts_pkg::ACT_SET_READY,  12345, 0, rrts_pkg::STAT_READY,
                0, 1, 0,    0,    rrts_pkg::ERR_UNKNOWN, 1);
        // target is stored unchecked, then the yield misses it
        add_row(rrts_pkg::ACT_SET_TARGET, 65535, 0, rrts_pkg::STAT_READY,
                0, 1, 0,    0,    rrts_pkg::ERR_OK,      1);
        add_row(rrts_pkg::ACT_YIELD,      0,     0, rrts_pkg::STAT_READY,
                0, 1, 0,    0,    rrts_pkg::ERR_UNKNOWN, 1);
        add_row(rrts_pkg::ACT_SET_TARGET, 1001,  0, rrts_pkg::STAT_READY,
                0, 1, 0,    0,    rrts_pkg::ERR_OK,      1);
        add_row(rrts_pkg::ACT_YIELD,      0,     0, rrts_pkg::STAT_READY,
                0, 1, 1001, 0,    rrts_pkg::ERR_OK,      1);
        add_row(rrts_pkg::ACT_YIELD,      0,     0, rrts_pkg::STAT_READY,
                0, 1, 0,    1001, rrts_pkg::ERR_OK,      1);
        // status above dead is skipped by round robin
        add_row(rrts_pkg::ACT_SET_STATUS, 1000,  0, 3'd6,
                0, 1, 0,    0,    rrts_pkg::ERR_OK,      1);
        add_row(rrts_pkg::ACT_YIELD,      0,     0, rrts_pkg::STAT_READY,
                0, 1, 1001, 0,    rrts_pkg::ERR_OK,      1);
        add_row(ACT_UNUSED_LO,            65535, 1, STAT_TOP,
                1, 1, 0,    0,    rrts_pkg::ERR_OK,      1);
        add_row(ACT_UNUSED_HI,            0,     0, rrts_pkg::STAT_READY,
                0, 1, 0,    0,    rrts_pkg::ERR_OK,      1);
        // directed switch to self
        add_row(rrts_pkg::ACT_SET_TARGET, 1001,  0, rrts_pkg::STAT_READY,
                0, 1, 0,    0,    rrts_pkg::ERR_OK,      1);
        add_row(rrts_pkg::ACT_YIELD,      0,     0, rrts_pkg::STAT_READY,
                0, 1, 1001, 1001, rrts_pkg::ERR_OK,      1);
        add_row(rrts_pkg::ACT_CREATE,     0,     0, rrts_pkg::STAT_READY,
                0, 0, 0,    0,    rrts_pkg::ERR_OK,      13);
        add_row(rrts_pkg::ACT_CREATE,     0,     0, rrts_pkg::STAT_READY,
                0, 1, 0,    0,    rrts_pkg::ERR_FULL,    1);
        add_row(rrts_pkg::ACT_CREATE,     0,     1, rrts_pkg::STAT_READY,
                0, 1, 0,    0,    rrts_pkg::ERR_OK,      1);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < directed.size(); i++)
            for (n = 0; n < directed[i].copies; n++)
                issue(directed[i].cmd, directed[i].known, directed[i].want, 1'b0);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i >= 200 && i < 350) || (i >= 900 && i < 1050);
            issue(make_random_command(), 1'b0, blank, i == 500 || i == 1200);
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
hdl/rrts_pkg.sv
hdl/rrts_ram.sv
hdl/rrts_scan.sv
hdl/round_robin_task_selector.sv
hdl/rrts_checker.sv
sim/testbench.sv
